// ===== sv/mis_pkg.sv =====
// shared types for the merge insertion sorter
package mis_pkg;

  localparam int unsigned ValueW = 32;

  typedef logic signed [ValueW-1:0] value_t;

  typedef struct packed {
    logic   valid;
    logic   shift;
    value_t value;
  } mis_link_t;

endpackage

// ===== sv/mis_cell.sv =====
// one sorting cell: holds a single value, inserts by broadcast compare, drains leftwards
module mis_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ins_en,
  input  logic               drain_en,
  input  mis_pkg::value_t    ins_value,
  input  mis_pkg::mis_link_t left_link,
  input  mis_pkg::mis_link_t right_link,
  output mis_pkg::mis_link_t cell_link
);

  logic            valid_r;
  logic            valid_nxt;
  mis_pkg::value_t value_r;
  mis_pkg::value_t value_nxt;
  logic            shift;

  assign shift = valid_r && (ins_value < value_r);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (drain_en) begin
      valid_nxt = right_link.valid;
      value_nxt = right_link.value;
    end else if (ins_en) begin
      if (left_link.shift) begin
        valid_nxt = 1'b1;
        value_nxt = left_link.value;
      end else if (shift || (!valid_r && left_link.valid)) begin
        valid_nxt = 1'b1;
        value_nxt = ins_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

  assign cell_link.valid = valid_r;
  assign cell_link.shift = shift;
  assign cell_link.value = value_r;

endmodule

// ===== sv/merge_insertion_sorter.sv =====
// merge insertion sorter top level: chain of insertion cells plus output register
// loading takes one beat per cycle while in_stall is low; each value is put in
// sorted place as it is accepted, unless the chain is full; after the final beat
// results go out one per cycle while out_stall allows; the input stalls while draining
// reset clears the cell valid bits, the overflow flag and the output valid bit
module merge_insertion_sorter #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [31:0]     in_item_value,
  input  logic                   in_item_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     out_sorted_value,
  output logic                   out_sorted_last,
  output logic                   out_overflowed
);

  mis_pkg::mis_link_t cell_links  [MAX_ITEMS];
  mis_pkg::mis_link_t left_links  [MAX_ITEMS];
  mis_pkg::mis_link_t right_links [MAX_ITEMS];

  logic            draining_r, draining_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_valid_r, out_valid_nxt;
  mis_pkg::value_t out_value_r, out_value_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic accept;
  logic full;
  logic ins_en;
  logic pop;

  assign full   = cell_links[MAX_ITEMS-1].valid;
  assign accept = in_valid && !draining_r;
  assign ins_en = accept && !full;
  assign pop    = draining_r && cell_links[0].valid && (!out_valid_r || !out_stall);

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign left_links[gi] = '{valid: 1'b1, shift: 1'b0, value: '0};
      end else begin : g_mid
        assign left_links[gi] = cell_links[gi-1];
      end
      if (gi == MAX_ITEMS - 1) begin : g_tail
        assign right_links[gi] = '{valid: 1'b0, shift: 1'b0, value: '0};
      end else begin : g_body
        assign right_links[gi] = cell_links[gi+1];
      end

      mis_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ins_en     (ins_en),
        .drain_en   (pop),
        .ins_value  (in_item_value),
        .left_link  (left_links[gi]),
        .right_link (right_links[gi]),
        .cell_link  (cell_links[gi])
      );
    end
  endgenerate

  always_comb begin
    draining_nxt  = draining_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end
      if (in_item_last) begin
        draining_nxt = 1'b1;
      end
    end

    if (pop) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = cell_links[0].value;
      out_last_nxt  = !right_links[0].valid;
      out_ovf_nxt   = ovf_r;
      if (!right_links[0].valid) begin
        draining_nxt = 1'b0;
        ovf_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r  <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      draining_r  <= draining_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign in_stall         = draining_r;
  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_sorted_last  = out_last_r;
  assign out_overflowed   = out_ovf_r;

endmodule
